// ----- design/tsms_pkg.sv -----
// Shared types and constants for the timed shutter move scheduler.
// No dependencies; imported by tsms_cell and timed_shutter_move_scheduler_unit.
package tsms_pkg;

    localparam int SHUTTERS   = 5;
    localparam int MOVE_SLOTS = 8;
    localparam int FULL_SCALE = 1000;

    localparam int SH_W   = 3;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 4;
    localparam int TIME_W = 22;
    localparam int TGT_W  = 16;
    localparam int MAG_W  = 16;
    localparam int MS_W   = 8;
    localparam int PROD_W = MAG_W + MS_W;

    localparam logic [TIME_W-1:0] TIME_MAX     = TIME_W'(4194303);
    localparam logic [TIME_W-1:0] DURATION_MAX = TIME_W'(4194302);
    localparam logic [MS_W-1:0]   MS_RESET     = MS_W'(40);

    localparam logic [1:0] DRV_STOP = 2'b00;
    localparam logic [1:0] DRV_UP   = 2'b01;
    localparam logic [1:0] DRV_DOWN = 2'b11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT,
        ST_MUL,
        ST_DROP,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [SH_W-1:0]   channel;
        logic              up;
        logic              running;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] duration;
    } t_move;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic [SH_W-1:0] channel;
        logic [1:0]      drive;
        logic            dropped;
    } t_res;

endpackage

// ----- design/tsms_cell.sv -----
// One move slot of the queue chain: takes its right neighbor on a shift,
// or a fresh or updated entry on a load. Depends on tsms_pkg.
module tsms_cell (
    input  logic               i_clk,
    input  tsms_pkg::t_cell_ctl i_ctl,
    input  tsms_pkg::t_move    i_right,
    input  tsms_pkg::t_move    i_load,
    output tsms_pkg::t_move    o_q
);
    import tsms_pkg::*;

    t_move r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_q <= i_load;
        end else if (i_ctl.shift) begin
            r_q <= i_right;
        end
    end

    assign o_q = r_q;

endmodule

// ----- design/timed_shutter_move_scheduler_unit.sv -----
// Top level of the timed shutter move scheduler: sequencer, position table
// and a chain of tsms_cell move slots. Depends on tsms_pkg and tsms_cell.
//
//  channel   dir  tdata bits (low first)         tuser     tlast
//  s_axis    in   shutter[2:0] target[18:3]      kind      -
//  m_axis    out  channel[2:0] drive[4:3]        dropped   last
//  cfg       in   ms_per_unit (i_cfg_wdata)      -         -
//
// A target request is latched, compared, multiplied and enqueued; an ignored one
// ends after the compare, one meeting a full queue waits for the output. A tick
// rotates the queue through the head cell one slot per cycle while not stalled.
// Reset is synchronous: queue empty, positions zero, ms_per_unit 40.
// Output stalls hold the walk only on slots that produce a command.
module timed_shutter_move_scheduler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // shutter[2:0], target[18:3], zero pad
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // channel[2:0], drive[4:3], zero pad
    output logic        m_axis_tuser,   // dropped
    output logic        m_axis_tlast
);
    import tsms_pkg::*;

    t_state r_state, n_state;

    logic [MS_W-1:0]   r_ms;
    logic [POS_W-1:0]  r_pos [SHUTTERS];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_steps;
    logic [SH_W-1:0]   r_sh;
    logic [TGT_W-1:0]  r_tgt;
    logic [MAG_W-1:0]  r_mag;
    logic              r_up;

    t_res              r_out;
    logic              r_out_last;
    logic              r_out_valid;
    t_res              r_pend;
    logic              r_pend_valid;

    t_move             w_q [MOVE_SLOTS];
    t_cell_ctl         w_ctl [MOVE_SLOTS];
    t_move             w_load;
    t_move             w_upd;
    t_move             w_new;
    t_move             w_head;

    logic              w_sh_ok;
    logic [TGT_W:0]    w_delta;
    logic [TGT_W:0]    w_abs;
    logic [POS_W-1:0]  w_clamp;
    logic [PROD_W-1:0] w_prod;
    logic [TIME_W-1:0] w_dur;
    logic [TIME_W-1:0] w_inc;
    logic              w_done;
    logic              w_emit;
    logic              w_keep;
    logic              w_out_free;
    logic              w_step;
    logic              w_enq;
    logic              w_tgt_go;
    t_res              w_step_res;

    // target compare
    assign w_sh_ok = ({1'b0, r_sh} < (SH_W + 1)'(SHUTTERS));
    assign w_delta = $signed({r_tgt[TGT_W-1], r_tgt})
                   - $signed({(TGT_W + 1 - POS_W)'(0), r_pos[r_sh]});
    assign w_abs   = w_delta[TGT_W] ? (TGT_W + 1)'(-w_delta) : w_delta;

    always_comb begin
        if (r_tgt[TGT_W-1]) begin
            w_clamp = '0;
        end else if (r_tgt > TGT_W'(FULL_SCALE)) begin
            w_clamp = POS_W'(FULL_SCALE);
        end else begin
            w_clamp = r_tgt[POS_W-1:0];
        end
    end

    assign w_prod = PROD_W'(r_mag) * PROD_W'(r_ms);
    assign w_dur  = (w_prod > PROD_W'(DURATION_MAX)) ? DURATION_MAX
                                                     : w_prod[TIME_W-1:0];

    always_comb begin
        w_new          = '0;
        w_new.channel  = r_sh;
        w_new.up       = r_up;
        w_new.duration = w_dur;
    end

    // head slot update
    assign w_head = w_q[0];
    assign w_inc  = (w_head.elapsed == TIME_MAX) ? w_head.elapsed
                                                 : w_head.elapsed + TIME_W'(1);
    assign w_done = w_head.running && (w_inc > w_head.duration);
    assign w_emit = !w_head.running || w_done;
    assign w_keep = !w_done;

    always_comb begin
        w_upd         = w_head;
        w_upd.running = 1'b1;
        w_upd.elapsed = w_head.running ? w_inc : '0;
        w_step_res.channel = w_head.channel;
        w_step_res.dropped = 1'b0;
        if (w_head.running) begin
            w_step_res.drive = DRV_STOP;
        end else if (w_head.up) begin
            w_step_res.drive = DRV_UP;
        end else begin
            w_step_res.drive = DRV_DOWN;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = s_axis_tuser ? ST_WALK : ST_TGT;
                end
            end
            ST_TGT: begin
                if (!w_sh_ok || w_delta == '0) begin
                    n_state = ST_IDLE;
                end else if (r_cnt >= CNT_W'(MOVE_SLOTS)) begin
                    n_state = ST_DROP;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_IDLE;
            ST_DROP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                if (r_steps == '0) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_step        = 1'b0;
        w_enq         = 1'b0;
        w_tgt_go      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_TGT:   w_tgt_go = w_sh_ok && (w_delta != '0)
                                 && (r_cnt < CNT_W'(MOVE_SLOTS));
            ST_MUL:   w_enq = 1'b1;
            ST_WALK:  w_step = (r_steps != '0) && (!w_emit || w_out_free);
            ST_DROP, ST_FLUSH: ;
            default:  ;
        endcase
    end

    assign w_load = w_enq ? w_new : w_upd;

    genvar k;
    generate
        for (k = 0; k < MOVE_SLOTS; k++) begin : g_cell
            t_move w_right;
            if (k == MOVE_SLOTS - 1) begin : g_end
                assign w_right = w_load;
            end else begin : g_mid
                assign w_right = w_q[k+1];
            end
            assign w_ctl[k].shift = w_step;
            assign w_ctl[k].load  = (w_step && w_keep && (CNT_W'(k + 1) == r_cnt))
                                  || (w_enq && (CNT_W'(k) == r_cnt));
            tsms_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl[k]),
                .i_right(w_right),
                .i_load (w_load),
                .o_q    (w_q[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ms         <= MS_RESET;
            r_cnt        <= '0;
            r_steps      <= '0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
            for (int s = 0; s < SHUTTERS; s++) begin
                r_pos[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ms <= i_cfg_wdata;
            end
            if (r_state == ST_IDLE && s_axis_tvalid) begin
                r_sh    <= s_axis_tdata[SH_W-1:0];
                r_tgt   <= s_axis_tdata[SH_W +: TGT_W];
                r_steps <= r_cnt;
            end
            if (w_tgt_go) begin
                r_mag       <= w_abs[MAG_W-1:0];
                r_up        <= !w_delta[TGT_W];
                r_pos[r_sh] <= w_clamp;
            end
            if (w_enq) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_step) begin
                r_steps <= r_steps - CNT_W'(1);
                if (!w_keep) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end

            // result register and one-deep pending slot for tlast
            if (w_step && w_emit) begin
                if (r_pend_valid) begin
                    r_out       <= r_pend;
                    r_out_last  <= 1'b0;
                    r_out_valid <= 1'b1;
                end else if (r_out_valid && m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                r_pend       <= w_step_res;
                r_pend_valid <= 1'b1;
            end else if (r_state == ST_FLUSH && r_pend_valid && w_out_free) begin
                r_out        <= r_pend;
                r_out_last   <= 1'b1;
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (r_state == ST_DROP && w_out_free) begin
                r_out.channel <= r_sh;
                r_out.drive   <= DRV_STOP;
                r_out.dropped <= 1'b1;
                r_out_last    <= 1'b1;
                r_out_valid   <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.drive, r_out.channel};
    assign m_axis_tuser  = r_out.dropped;
    assign m_axis_tlast  = r_out_last;

endmodule
